>>> hdl/ugsc_pkg.sv
// shared types and constants for the uv generator start controller
package ugsc_pkg;

  // generator mode codes
  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_STARTING    = 4'd1,
    MODE_START_CONT  = 4'd2,
    MODE_CHARGING    = 4'd3,
    MODE_RUNNING     = 4'd4,
    MODE_SEARCH      = 4'd5,
    MODE_SEARCH_RUN  = 4'd6,
    MODE_SEARCH_NOFB = 4'd7,
    MODE_NOFB        = 4'd8,
    MODE_STOPPED     = 4'd9
  } mode_t;

  // command and event codes
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_FEEDBACK = 3'd1,
    OP_RECHARGE = 3'd2,
    OP_SEARCH   = 3'd3,
    OP_START_ON = 3'd4,
    OP_STOP     = 3'd5,
    OP_ENABLE   = 3'd6
  } op_t;

  // configuration register indexes
  localparam logic [2:0] REG_DUTY_MIN     = 3'd0;
  localparam logic [2:0] REG_DUTY_MAX     = 3'd1;
  localparam logic [2:0] REG_FB_OK_COUNT  = 3'd2;
  localparam logic [2:0] REG_CHARGE_TICKS = 3'd3;
  localparam logic [2:0] REG_FB_CALL_LIM  = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // configuration reset values
  localparam logic [7:0] DUTY_MIN_RST     = 8'd25;
  localparam logic [7:0] DUTY_MAX_RST     = 8'd30;
  localparam logic [7:0] FB_OK_COUNT_RST  = 8'd5;
  localparam logic [7:0] CHARGE_TICKS_RST = 8'd71;
  localparam logic [7:0] FB_CALL_LIM_RST  = 8'd100;
  localparam logic [7:0] DUTY_RST         = 8'd25;

  typedef struct packed {
    logic [7:0] duty_min;
    logic [7:0] duty_max;
    logic [7:0] fb_ok_count;
    logic [7:0] charge_ticks;
    logic [7:0] fb_call_limit;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] duty;
    logic       pwm_on;
    logic       timer_on;
    logic       fb_on;
    logic [7:0] fb_count;
    logic [7:0] fb_calls;
    logic [7:0] charge_count;
  } ctl_state_t;

  typedef struct packed {
    logic [2:0] op;
    logic       continuous;
    logic [7:0] start_duty;
  } req_t;

endpackage

>>> hdl/ugsc_if.sv
// request and result channel interfaces
interface ugsc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic       continuous;
  logic [7:0] start_duty;

  modport source (output valid, op, continuous, start_duty, input ready);
  modport sink (input valid, op, continuous, start_duty, output ready);
endinterface

interface ugsc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [7:0] duty;
  logic       pwm_enabled;
  logic       ramp_timer_enabled;
  logic       feedback_enabled;
  logic [7:0] feedback_count;
  logic [7:0] feedback_calls;
  logic [7:0] charge_count;
  logic       accepted;

  modport source (output valid, mode, duty, pwm_enabled, ramp_timer_enabled,
                  feedback_enabled, feedback_count, feedback_calls, charge_count,
                  accepted, input ready);
  modport sink (input valid, mode, duty, pwm_enabled, ramp_timer_enabled,
                feedback_enabled, feedback_count, feedback_calls, charge_count,
                accepted, output ready);
endinterface

>>> hdl/ugsc_step.sv
// next-state logic for one command or event
module ugsc_step (
  input  ugsc_pkg::ctl_state_t cur,
  input  ugsc_pkg::cfg_t       cfg,
  input  ugsc_pkg::req_t       req,
  output ugsc_pkg::ctl_state_t nxt,
  output logic                 accepted
);
  import ugsc_pkg::*;

  // fresh start into a mode with a first duty
  function automatic ctl_state_t launch(ctl_state_t s, mode_t to_mode,
                                        logic [7:0] first_duty);
    ctl_state_t r;
    r              = s;
    r.mode         = to_mode;
    r.fb_count     = 8'd0;
    r.fb_calls     = 8'd0;
    r.charge_count = 8'd0;
    r.fb_on        = 1'b1;
    r.duty         = first_duty;
    r.pwm_on       = 1'b1;
    r.timer_on     = (to_mode == MODE_STARTING) || (to_mode == MODE_START_CONT) ||
                     (to_mode == MODE_SEARCH);
    return r;
  endfunction

  logic [8:0] duty_inc;
  logic [7:0] calls_inc;
  logic [7:0] fb_inc;
  op_t        op;

  assign duty_inc  = {1'b0, cur.duty} + 9'd1;
  assign calls_inc = cur.fb_calls + 8'd1;
  assign fb_inc    = cur.fb_count + 8'd1;
  assign op        = op_t'(req.op);

  // decode the request and update the state
  always_comb begin
    nxt      = cur;
    accepted = 1'b1;
    unique case (op)
      OP_TICK: begin
        if (cur.timer_on) begin
          if (cur.mode == MODE_CHARGING) begin
            nxt.charge_count = cur.charge_count + 8'd1;
            if (cur.charge_count > cfg.charge_ticks) begin
              nxt.pwm_on   = 1'b0;
              nxt.timer_on = 1'b0;
              nxt.fb_on    = 1'b0;
              nxt.mode     = MODE_IDLE;
            end
          end else if (cur.mode == MODE_SEARCH_RUN || cur.mode == MODE_START_CONT) begin
            nxt.timer_on = 1'b0;
          end else if (duty_inc > {1'b0, cfg.duty_max}) begin
            nxt.pwm_on   = 1'b0;
            nxt.timer_on = 1'b0;
            nxt.fb_on    = 1'b0;
            nxt.mode     = (cur.mode == MODE_SEARCH) ? MODE_SEARCH_NOFB : MODE_NOFB;
          end else begin
            nxt.duty = duty_inc[7:0];
          end
        end
      end
      OP_FEEDBACK: begin
        if (cur.fb_on) begin
          nxt.fb_calls = calls_inc;
          if (calls_inc > cfg.fb_call_limit) begin
            nxt.fb_on = 1'b0;
          end
          if (fb_inc > cfg.fb_ok_count) begin
            if (cur.mode == MODE_STARTING) begin
              nxt.fb_on = 1'b0;
              nxt.mode  = MODE_CHARGING;
            end else if (cur.mode == MODE_START_CONT) begin
              nxt.fb_on    = 1'b0;
              nxt.timer_on = 1'b0;
              nxt.mode     = MODE_RUNNING;
            end else if (cur.mode == MODE_SEARCH) begin
              nxt.fb_on    = 1'b0;
              nxt.timer_on = 1'b0;
              nxt.mode     = MODE_SEARCH_RUN;
            end
          end else begin
            nxt.fb_count = fb_inc;
          end
        end
      end
      OP_RECHARGE: begin
        if (cur.mode == MODE_IDLE || cur.mode == MODE_NOFB) begin
          nxt = launch(cur, req.continuous ? MODE_START_CONT : MODE_STARTING,
                       cfg.duty_min);
        end else if (cur.mode == MODE_STARTING || cur.mode == MODE_START_CONT ||
                     cur.mode == MODE_RUNNING) begin
          if (!req.continuous && cur.mode != MODE_STARTING) begin
            nxt = launch(cur, MODE_STARTING, cfg.duty_min);
          end
        end else begin
          accepted = 1'b0;
        end
      end
      OP_SEARCH: begin
        nxt = launch(cur, MODE_SEARCH, cfg.duty_min);
      end
      OP_START_ON: begin
        nxt = launch(cur, MODE_SEARCH_RUN, req.start_duty);
      end
      OP_STOP: begin
        nxt.pwm_on   = 1'b0;
        nxt.timer_on = 1'b0;
        nxt.fb_on    = 1'b0;
        nxt.mode     = MODE_STOPPED;
      end
      OP_ENABLE: begin
        if (cur.mode == MODE_STOPPED) begin
          nxt.mode = MODE_IDLE;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

>>> hdl/uv_generator_start_controller.sv
// top level of the uv generator start controller
//
// Usage: each request on in_ch is one command or event (ramp tick, feedback
// edge, recharge, start search, start on, stop, enable). Every request gives
// exactly one result on out_ch: the generator state after that request plus
// the accepted flag of a recharge.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// by the user only while no request is in flight (not enforced by the block);
// writes take effect at the next edge. A request is held in the request
// register, then its result in the result register, from where it shows on
// out_ch. Throughput: one request per cycle while out_ch is not stalled,
// set by the single step of next-state logic between the request register
// and the result register.
// Reset (rst_n low, synchronous) returns the mode to idle, duty to 25, all
// enables and counters to zero and the registers to their default values.
// When the receiver stalls, the result holds on out_ch, one more request
// waits in the request register and in_ch.ready drops until out_ch moves.
module uv_generator_start_controller (
  input  logic            clk,
  input  logic            rst_n,
  ugsc_in_if.sink         in_ch,
  ugsc_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [ugsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ugsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ugsc_pkg::*;

  cfg_t       cfg_r;
  ctl_state_t st_r;
  ctl_state_t st_nxt;
  req_t       req_r;
  logic       req_v_r;
  logic       step_acc;
  logic       out_v_r;
  logic       out_acc_r;
  ctl_state_t out_st_r;
  logic       advance;

  // handshake: request stage moves when the result register is free
  assign advance     = req_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !req_v_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_min      <= DUTY_MIN_RST;
      cfg_r.duty_max      <= DUTY_MAX_RST;
      cfg_r.fb_ok_count   <= FB_OK_COUNT_RST;
      cfg_r.charge_ticks  <= CHARGE_TICKS_RST;
      cfg_r.fb_call_limit <= FB_CALL_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DUTY_MIN:     cfg_r.duty_min      <= cfg_data;
        REG_DUTY_MAX:     cfg_r.duty_max      <= cfg_data;
        REG_FB_OK_COUNT:  cfg_r.fb_ok_count   <= cfg_data;
        REG_CHARGE_TICKS: cfg_r.charge_ticks  <= cfg_data;
        REG_FB_CALL_LIM:  cfg_r.fb_call_limit <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r.op         <= in_ch.op;
      req_r.continuous <= in_ch.continuous;
      req_r.start_duty <= in_ch.start_duty;
    end
  end

  // next-state logic
  ugsc_step u_step (
    .cur      (st_r),
    .cfg      (cfg_r),
    .req      (req_r),
    .nxt      (st_nxt),
    .accepted (step_acc)
  );

  // generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= MODE_IDLE;
      st_r.duty         <= DUTY_RST;
      st_r.pwm_on       <= 1'b0;
      st_r.timer_on     <= 1'b0;
      st_r.fb_on        <= 1'b0;
      st_r.fb_count     <= 8'd0;
      st_r.fb_calls     <= 8'd0;
      st_r.charge_count <= 8'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_st_r  <= st_nxt;
      out_acc_r <= step_acc;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.mode               = out_st_r.mode;
  assign out_ch.duty               = out_st_r.duty;
  assign out_ch.pwm_enabled        = out_st_r.pwm_on;
  assign out_ch.ramp_timer_enabled = out_st_r.timer_on;
  assign out_ch.feedback_enabled   = out_st_r.fb_on;
  assign out_ch.feedback_count     = out_st_r.fb_count;
  assign out_ch.feedback_calls     = out_st_r.fb_calls;
  assign out_ch.charge_count       = out_st_r.charge_count;
  assign out_ch.accepted           = out_acc_r;

endmodule

>>> tb/sv/ugsc_checker.sv
// checker for the uv generator start controller: predicts each result and compares it
module ugsc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  ugsc_in_if                              req_ch,
  ugsc_out_if                             res_ch,
  input  logic                            cfg_we,
  input  logic [ugsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ugsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              pending_results,
  output int                              mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ugsc_pkg::*;

  typedef struct packed {
    ctl_state_t st;
    logic       acc;
  } gen_result_t;

  // shadow copy of the generator state and its registers
  ctl_state_t  gen;
  cfg_t        regs;
  gen_result_t expected_states[$];
  gen_result_t want_res;
  logic        want_acc;

  // all outputs off, duty and counters kept
  function automatic void halt_generator();
    gen.pwm_on   = 1'b0;
    gen.timer_on = 1'b0;
    gen.fb_on    = 1'b0;
  endfunction

  // fresh start in a given mode with a given first duty
  function automatic void launch_generator(mode_t m, logic [7:0] first_duty);
    gen.mode         = m;
    gen.fb_count     = 8'd0;
    gen.fb_calls     = 8'd0;
    gen.charge_count = 8'd0;
    gen.fb_on        = 1'b1;
    gen.duty         = first_duty;
    gen.pwm_on       = 1'b1;
    gen.timer_on     = (m == MODE_STARTING) || (m == MODE_START_CONT) || (m == MODE_SEARCH);
  endfunction

  // apply one request to the shadow state, returns the accepted flag
  function automatic logic step_generator(logic [2:0] op, logic cont, logic [7:0] sd);
    logic       acc;
    logic [8:0] duty_up;
    logic [7:0] old_charge;
    logic [7:0] next_fb;
    acc = 1'b1;
    case (op)
      OP_TICK: begin
        if (gen.timer_on) begin
          if (gen.mode == MODE_CHARGING) begin
            old_charge       = gen.charge_count;
            gen.charge_count = old_charge + 8'd1;
            if (old_charge > regs.charge_ticks) begin
              halt_generator();
              gen.mode = MODE_IDLE;
            end
          end else if (gen.mode == MODE_SEARCH_RUN || gen.mode == MODE_START_CONT) begin
            gen.timer_on = 1'b0;
          end else begin
            duty_up = {1'b0, gen.duty} + 9'd1;
            if (duty_up > {1'b0, regs.duty_max}) begin
              halt_generator();
              gen.mode = (gen.mode == MODE_SEARCH) ? MODE_SEARCH_NOFB : MODE_NOFB;
            end else begin
              gen.duty = duty_up[7:0];
            end
          end
        end
      end
      OP_FEEDBACK: begin
        if (gen.fb_on) begin
          gen.fb_calls = gen.fb_calls + 8'd1;
          if (gen.fb_calls > regs.fb_call_limit) gen.fb_on = 1'b0;
          next_fb = gen.fb_count + 8'd1;
          if (next_fb > regs.fb_ok_count) begin
            if (gen.mode == MODE_STARTING) begin
              gen.fb_on = 1'b0;
              gen.mode  = MODE_CHARGING;
            end else if (gen.mode == MODE_START_CONT) begin
              gen.fb_on    = 1'b0;
              gen.timer_on = 1'b0;
              gen.mode     = MODE_RUNNING;
            end else if (gen.mode == MODE_SEARCH) begin
              gen.fb_on    = 1'b0;
              gen.timer_on = 1'b0;
              gen.mode     = MODE_SEARCH_RUN;
            end
          end else begin
            gen.fb_count = next_fb;
          end
        end
      end
      OP_RECHARGE: begin
        if (gen.mode == MODE_IDLE || gen.mode == MODE_NOFB) begin
          launch_generator(cont ? MODE_START_CONT : MODE_STARTING, regs.duty_min);
        end else if (gen.mode == MODE_STARTING || gen.mode == MODE_START_CONT ||
                     gen.mode == MODE_RUNNING) begin
          if (!cont && (gen.mode == MODE_RUNNING || gen.mode == MODE_START_CONT))
            launch_generator(MODE_STARTING, regs.duty_min);
        end else begin
          acc = 1'b0;
        end
      end
      OP_SEARCH:   launch_generator(MODE_SEARCH, regs.duty_min);
      OP_START_ON: launch_generator(MODE_SEARCH_RUN, sd);
      OP_STOP: begin
        halt_generator();
        gen.mode = MODE_STOPPED;
      end
      OP_ENABLE: begin
        if (gen.mode == MODE_STOPPED) gen.mode = MODE_IDLE;
      end
      default: ;
    endcase
    return acc;
  endfunction

  // one field of a result against its prediction
  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
    end
  endfunction

  // watch config writes, requests and results
  always @(posedge clk) begin
    if (!rst_n) begin
      gen                = '0;
      gen.mode           = MODE_IDLE;
      gen.duty           = DUTY_RST;
      regs.duty_min      = DUTY_MIN_RST;
      regs.duty_max      = DUTY_MAX_RST;
      regs.fb_ok_count   = FB_OK_COUNT_RST;
      regs.charge_ticks  = CHARGE_TICKS_RST;
      regs.fb_call_limit = FB_CALL_LIM_RST;
      expected_states.delete();
      mismatch_count     = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_DUTY_MIN:     regs.duty_min      = cfg_data;
          REG_DUTY_MAX:     regs.duty_max      = cfg_data;
          REG_FB_OK_COUNT:  regs.fb_ok_count   = cfg_data;
          REG_CHARGE_TICKS: regs.charge_ticks  = cfg_data;
          REG_FB_CALL_LIM:  regs.fb_call_limit = cfg_data;
          default: ;
        endcase
      end
      // result against the oldest prediction
      if (res_ch.valid && res_ch.ready) begin
        if (expected_states.size() == 0) begin
          mismatch_count++;
          $display("%0t: result expected none got mode %0d duty %0d", $time,
                   res_ch.mode, res_ch.duty);
        end else begin
          want_res = expected_states.pop_front();
          check_field("mode", 8'(want_res.st.mode), 8'(res_ch.mode));
          check_field("duty", want_res.st.duty, res_ch.duty);
          check_field("pwm_enabled", 8'(want_res.st.pwm_on), 8'(res_ch.pwm_enabled));
          check_field("ramp_timer_enabled", 8'(want_res.st.timer_on),
                      8'(res_ch.ramp_timer_enabled));
          check_field("feedback_enabled", 8'(want_res.st.fb_on), 8'(res_ch.feedback_enabled));
          check_field("feedback_count", want_res.st.fb_count, res_ch.feedback_count);
          check_field("feedback_calls", want_res.st.fb_calls, res_ch.feedback_calls);
          check_field("charge_count", want_res.st.charge_count, res_ch.charge_count);
          check_field("accepted", 8'(want_res.acc), 8'(res_ch.accepted));
        end
      end
      // new request moves the shadow state
      if (req_ch.valid && req_ch.ready) begin
        want_acc = step_generator(req_ch.op, req_ch.continuous, req_ch.start_duty);
        expected_states.push_back('{st: gen, acc: want_acc});
      end
    end
    pending_results <= expected_states.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench top for the uv generator start controller: stimulus, pacing and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ugsc_pkg::*;

  localparam logic [2:0] OP_UNDEFINED   = 3'd7;
  localparam int         HOLD_CYCLES    = 64;
  localparam int         DRAIN_PAD      = 6;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending_results;
  int                    mismatch_count;
  int                    burst_left;
  int                    quiet_cycles;
  bit                    hold_off_req;

  ugsc_in_if  req_if ();
  ugsc_out_if res_if ();

  uv_generator_start_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ugsc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ch          (req_if),
    .res_ch          (res_if),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: stretches of different stall patterns, long hold-off on demand
  initial begin
    int stretch;
    int style;
    res_if.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stretch = $urandom_range(4, 40);
        style   = $urandom_range(0, 3);
        for (int k = 0; k < stretch; k++) begin
          if (hold_off_req) break;
          case (style)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom);
            2:       res_if.ready <= ($urandom_range(0, 3) == 0);
            default: res_if.ready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // present one request and hold it until taken
  task automatic send_req(logic [2:0] op, logic cont, logic [7:0] sd);
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.continuous <= cont;
    req_if.start_duty <= sd;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // sender bursts with random gaps between them
  task automatic offer(logic [2:0] op, logic cont, logic [7:0] sd);
    int gap;
    send_req(op, cont, sd);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // stop sending and wait for every result
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // write all five registers while the block is idle
  task automatic program_regs(cfg_t c);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_DUTY_MIN;
    cfg_data <= c.duty_min;
    @(posedge clk);
    cfg_index <= REG_DUTY_MAX;
    cfg_data <= c.duty_max;
    @(posedge clk);
    cfg_index <= REG_FB_OK_COUNT;
    cfg_data <= c.fb_ok_count;
    @(posedge clk);
    cfg_index <= REG_CHARGE_TICKS;
    cfg_data <= c.charge_ticks;
    @(posedge clk);
    cfg_index <= REG_FB_CALL_LIM;
    cfg_data <= c.fb_call_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hand-picked requests at reset settings
  task automatic directed_part();
    // tick and feedback with their inputs off, undefined op
    offer(OP_TICK, 1'b0, 8'd0);
    offer(OP_FEEDBACK, 1'b1, 8'hff);
    offer(OP_UNDEFINED, 1'b1, 8'hff);
    // one-shot charge: ramp, feedback success, charging
    offer(OP_RECHARGE, 1'b0, 8'd0);
    offer(OP_TICK, 1'b0, 8'd0);
    repeat (6) offer(OP_FEEDBACK, 1'b0, 8'd0);
    offer(OP_RECHARGE, 1'b0, 8'd0);
    offer(OP_TICK, 1'b0, 8'd0);
    // stop, rejected recharge, enable back to idle
    offer(OP_STOP, 1'b0, 8'd0);
    offer(OP_RECHARGE, 1'b1, 8'd0);
    offer(OP_ENABLE, 1'b0, 8'd0);
    // continuous start, tick only drops the timer, one-shot restart
    offer(OP_RECHARGE, 1'b1, 8'd0);
    offer(OP_TICK, 1'b1, 8'd0);
    offer(OP_RECHARGE, 1'b0, 8'd0);
    // direct start with extreme duties and search
    offer(OP_START_ON, 1'b0, 8'hff);
    offer(OP_SEARCH, 1'b1, 8'h55);
    offer(OP_START_ON, 1'b1, 8'd0);
  endtask

  // start, stop or random command followed by a run of ticks and feedback edges
  task automatic run_sessions(int n_items, int max_run);
    int sent;
    int run;
    int tick_pct;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        offer(OP_RECHARGE, 1'($urandom), 8'($urandom));
      end else if (pick < 7) begin
        offer(OP_SEARCH, 1'($urandom), 8'($urandom));
      end else if (pick == 7) begin
        offer(OP_START_ON, 1'($urandom), 8'($urandom));
      end else if (pick == 8) begin
        offer(OP_STOP, 1'($urandom), 8'($urandom));
        offer(OP_ENABLE, 1'($urandom), 8'($urandom));
        sent++;
      end else begin
        offer(3'($urandom), 1'($urandom), 8'($urandom));
      end
      sent++;
      run = $urandom_range(1, max_run);
      if (run > n_items - sent) run = n_items - sent;
      case ($urandom_range(0, 4))
        0:       tick_pct = 0;
        1:       tick_pct = 25;
        2:       tick_pct = 50;
        3:       tick_pct = 85;
        default: tick_pct = 100;
      endcase
      for (int k = 0; k < run; k++) begin
        if ($urandom_range(0, 99) < 3)
          offer(3'($urandom), 1'($urandom), 8'($urandom));
        else if ($urandom_range(0, 99) < tick_pct)
          offer(OP_TICK, 1'($urandom), 8'($urandom));
        else
          offer(OP_FEEDBACK, 1'($urandom), 8'($urandom));
      end
      if (run > 0) sent += run;
    end
  endtask

  // back-to-back requests while the receiver holds off
  task automatic flood(int n);
    hold_off_req = 1'b1;
    send_req(OP_RECHARGE, 1'($urandom), 8'($urandom));
    repeat (n) begin
      if ($urandom_range(0, 1) == 0)
        send_req(OP_TICK, 1'($urandom), 8'($urandom));
      else
        send_req(OP_FEEDBACK, 1'($urandom), 8'($urandom));
    end
  endtask

  // main sequence
  initial begin
    cfg_t setting;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_DUTY_MIN;
    cfg_data          = '0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_TICK;
    req_if.continuous = 1'b0;
    req_if.start_duty = 8'd0;
    burst_left        = 0;
    hold_off_req      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed_part();
    run_sessions(150, 20);
    flood(24);

    // every register at zero
    setting = '0;
    program_regs(setting);
    run_sessions(120, 10);

    // duty limits at their top, the other registers one below it
    setting = '{duty_min: 8'd255, duty_max: 8'd255, fb_ok_count: 8'd254,
                charge_ticks: 8'd254, fb_call_limit: 8'd254};
    program_regs(setting);
    run_sessions(300, 300);

    // full duty ramp from zero
    setting = '{duty_min: 8'd0, duty_max: 8'd255, fb_ok_count: 8'd40,
                charge_ticks: 8'd30, fb_call_limit: 8'd254};
    program_regs(setting);
    run_sessions(200, 300);

    // random small settings
    repeat (3) begin
      setting.duty_min      = 8'($urandom_range(0, 40));
      setting.duty_max      = 8'(setting.duty_min + $urandom_range(0, 12));
      setting.fb_ok_count   = 8'($urandom_range(0, 8));
      setting.charge_ticks  = 8'($urandom_range(0, 20));
      setting.fb_call_limit = 8'($urandom_range(0, 12));
      program_regs(setting);
      run_sessions(110, 30);
      flood(20);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
